// ----- design/stake_weighted_selector_unit_macros.svh -----
// Assertion macros shared by the stake weighted selector modules.
// Each macro expects the clock clk and the active-low reset rst_n in scope.
`ifndef STAKE_WEIGHTED_SELECTOR_UNIT_MACROS_SVH
`define STAKE_WEIGHTED_SELECTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWSEL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWSEL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/swsel_pkg.sv -----
// Package for the stake weighted selector: field widths, operation, status and
// register codes, reset values, and the controller/datapath command and status types.
// No dependencies.
package swsel_pkg;

    // Default sizing of the stake table.
    localparam int DEF_MAX_PARTICIPANTS = 64;
    localparam int DEF_STAKE_BITS       = 16;

    // Port field widths.
    localparam int OP_W       = 2;
    localparam int ENTRY_W    = 6;
    localparam int VALUE_W    = 16;
    localparam int RAND_W     = 31;
    localparam int VCOUNT_W   = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACTIVE_W   = 7;

    // The modulo runs one quotient bit per cycle.
    localparam int DIV_CNT_W = $clog2(RAND_W);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_SETTLE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PENDING = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PENALTY      = 2'd2;

    // Configuration reset values.
    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET  = 7'd4;
    localparam logic [CFG_DATA_W-1:0] REWARD_RESET  = 16'd5;
    localparam logic [CFG_DATA_W-1:0] PENALTY_RESET = 16'd10;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;   // write zero at the sweep address and advance
        logic capture;      // latch the input transaction
        logic scan_init;    // restart the table scan and the accumulator
        logic sum_step;     // one step of the stake sum
        logic div_init;     // start the modulo
        logic div_step;     // one quotient bit of the modulo
        logic walk_step;    // one step of the prefix-sum walk
        logic load_write;   // store a loaded stake and form its result
        logic settle_read;  // read the pending participant's stake
        logic settle_write; // update that stake and form the result
        logic res_zero;     // result for a zero total stake
        logic res_nopend;   // result for a settle with nothing pending
        logic res_blank;    // result for an unused operation
        logic emit;         // move the result into the output register
    } swsel_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;   // the sweep is at the last table entry
        logic scan_done;    // no read issued and none in flight
        logic total_zero;   // accumulator holds zero
        logic div_last;     // last quotient bit of the modulo
        logic hit;          // the running sum passed the target
        logic pend_valid;   // a selection is pending
    } swsel_stat_t;

endpackage

// ----- design/swsel_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
module swsel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/swsel_ctrl.sv -----
// Controller of the stake weighted selector: sequences the clearing pass, the
// operations and the result handoff. Depends on swsel_pkg and the macro header.
`include "stake_weighted_selector_unit_macros.svh"

module swsel_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [swsel_pkg::OP_W-1:0]   op,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  swsel_pkg::swsel_stat_t       stat,
    output swsel_pkg::swsel_cmd_t        cmd
);
    import swsel_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_LOAD   = 9'b000000100,
        S_SUM    = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_WALK   = 9'b000100000,
        S_SRD    = 9'b001000000,
        S_SWR    = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture   = 1'b1;
                    cmd.scan_init = 1'b1;
                    unique case (op)
                        OP_LOAD:   state_next = S_LOAD;
                        OP_SELECT: state_next = S_SUM;
                        OP_SETTLE:
                        begin
                            if (stat.pend_valid)
                            begin
                                state_next = S_SRD;
                            end
                            else
                            begin
                                cmd.res_nopend = 1'b1;
                                state_next     = S_FINISH;
                            end
                        end
                        default:
                        begin
                            cmd.res_blank = 1'b1;
                            state_next    = S_FINISH;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_write = 1'b1;
                state_next     = S_FINISH;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.total_zero)
                    begin
                        cmd.res_zero = 1'b1;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SRD:
            begin
                cmd.settle_read = 1'b1;
                state_next      = S_SWR;
            end
            S_SWR:
            begin
                cmd.settle_write = 1'b1;
                state_next       = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a new result, cleared when the transaction completes.
    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // A result never overwrites one that is still waiting.
    `SWSEL_ASSERT_SAME(a_emit_free, cmd.emit, !out_valid_reg || out_ready, "result overwritten")
    // An accepted transaction makes the block busy.
    `SWSEL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    // Inputs are held off while the table is being cleared.
    `SWSEL_ASSERT_SAME(a_clear_blocks, cmd.clear_step, !in_ready, "ready during clear")

endmodule

// ----- design/swsel_dp.sv -----
// Datapath of the stake weighted selector: configuration registers, stake
// memory, sum/walk accumulator, bit-serial modulo, settle arithmetic and the
// output register. Depends on swsel_pkg, swsel_ram and the macro header.
`include "stake_weighted_selector_unit_macros.svh"

module swsel_dp #(
    parameter int MAX_PARTICIPANTS = swsel_pkg::DEF_MAX_PARTICIPANTS,
    parameter int STAKE_BITS       = swsel_pkg::DEF_STAKE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swsel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swsel_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [swsel_pkg::ENTRY_W-1:0]      entry,
    input  logic [swsel_pkg::VALUE_W-1:0]      stake_value,
    input  logic [swsel_pkg::RAND_W-1:0]       random_value,
    input  logic [swsel_pkg::VCOUNT_W-1:0]     verified_count,
    output logic [swsel_pkg::STATUS_W-1:0]     status,
    output logic [swsel_pkg::ENTRY_W-1:0]      chosen,
    output logic [swsel_pkg::VALUE_W-1:0]      stake_now,
    output logic                               approved,
    input  swsel_pkg::swsel_cmd_t              cmd,
    output swsel_pkg::swsel_stat_t             stat
);
    import swsel_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICIPANTS);
    localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);
    localparam int TOT_W = STAKE_BITS + CNT_W;
    localparam int ADD_W = ((STAKE_BITS > VALUE_W) ? STAKE_BITS : VALUE_W) + 1;
    localparam logic [STAKE_BITS-1:0] STAKE_MAX = {STAKE_BITS{1'b1}};
    localparam logic [ADD_W-1:0] STAKE_MAX_EXT =
        {{(ADD_W - STAKE_BITS){1'b0}}, STAKE_MAX};

    // Configuration registers.
    logic [ACTIVE_W-1:0]   active_reg;
    logic [CFG_DATA_W-1:0] reward_reg;
    logic [CFG_DATA_W-1:0] penalty_reg;

    // Captured transaction fields.
    logic [ENTRY_W-1:0]  entry_reg;
    logic [VALUE_W-1:0]  stake_in_reg;
    logic [RAND_W-1:0]   rnd_reg;
    logic [VCOUNT_W-1:0] verified_reg;

    // Scan, modulo and pending-selection state.
    logic [CNT_W-1:0]     addr_reg,     addr_next;
    logic                 rd_pend_reg,  rd_pend_next;
    logic [IDX_W-1:0]     idx_d_reg,    idx_d_next;
    logic [TOT_W-1:0]     acc_reg,      acc_next;
    logic [TOT_W-1:0]     rem_reg,      rem_next;
    logic [RAND_W-1:0]    dvd_reg,      dvd_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg,  div_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_choice_reg, pend_choice_next;

    // Result waiting for the output register, and the output register.
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ENTRY_W-1:0]  res_chosen_reg, res_chosen_next;
    logic [VALUE_W-1:0]  res_stake_reg,  res_stake_next;
    logic                res_appr_reg,   res_appr_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ENTRY_W-1:0]  out_chosen_reg;
    logic [VALUE_W-1:0]  out_stake_reg;
    logic                out_appr_reg;

    // Memory ports.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [STAKE_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [STAKE_BITS-1:0] ram_rdata;

    // Combinational helpers.
    logic [CNT_W-1:0]      n_act;
    logic                  issue;
    logic [TOT_W-1:0]      acc_sum;
    logic                  hit;
    logic [TOT_W:0]        rem_sh;
    logic                  entry_ok;
    logic [IDX_W-1:0]      entry_idx;
    logic [STAKE_BITS-1:0] load_val;
    logic                  approve;
    logic [ADD_W-1:0]      s_ext;
    logic [ADD_W-1:0]      add_sum;
    logic [ADD_W-1:0]      pen_ext;
    logic [STAKE_BITS-1:0] settle_val;

    swsel_ram #(
        .WIDTH (STAKE_BITS),
        .DEPTH (MAX_PARTICIPANTS)
    ) u_stake_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Active participant count, limited to the table size.
    always_comb
    begin
        if (32'(active_reg) > MAX_PARTICIPANTS)
        begin
            n_act = CNT_W'(MAX_PARTICIPANTS);
        end
        else
        begin
            n_act = CNT_W'(active_reg);
        end
    end

    // Scan over the first n_act entries: one read per cycle, its data in the next cycle.
    assign issue   = (addr_reg < n_act);
    assign acc_sum = acc_reg + TOT_W'(ram_rdata);
    assign hit     = rd_pend_reg && (rem_reg < acc_sum);

    // One restoring step of the modulo.
    assign rem_sh = {rem_reg, dvd_reg[RAND_W-1]};

    // Load operand decode.
    assign entry_ok  = (32'(entry_reg) < MAX_PARTICIPANTS);
    assign entry_idx = IDX_W'(entry_reg);
    assign load_val  = STAKE_BITS'(stake_in_reg);

    // Settle arithmetic: reward saturates, penalty floors at zero.
    assign approve = (32'(verified_reg) > (32'(n_act) >> 1));
    assign s_ext   = ADD_W'(ram_rdata);
    assign add_sum = s_ext + ADD_W'(reward_reg);
    assign pen_ext = ADD_W'(penalty_reg);

    always_comb
    begin
        if (approve)
        begin
            settle_val = (add_sum > STAKE_MAX_EXT) ? STAKE_MAX : STAKE_BITS'(add_sum);
        end
        else if (s_ext > pen_ext)
        begin
            settle_val = STAKE_BITS'(s_ext - pen_ext);
        end
        else
        begin
            settle_val = '0;
        end
    end

    // Memory port selection.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg[IDX_W-1:0];
        ram_wdata = '0;
        priority if (cmd.clear_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.load_write)
        begin
            ram_we    = entry_ok;
            ram_waddr = entry_idx;
            ram_wdata = load_val;
        end
        else if (cmd.settle_write)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_choice_reg;
            ram_wdata = settle_val;
        end
        else
        begin
            ram_we = 1'b0;
        end
        ram_raddr = cmd.settle_read ? pend_choice_reg : addr_reg[IDX_W-1:0];
    end

    // Scan counter, accumulator and modulo next values.
    always_comb
    begin
        addr_next    = addr_reg;
        rd_pend_next = 1'b0;
        idx_d_next   = addr_reg[IDX_W-1:0];
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        div_cnt_next = div_cnt_reg;

        if (cmd.clear_step)
        begin
            addr_next = addr_reg + 1'b1;
        end
        else if (cmd.scan_init)
        begin
            addr_next = '0;
            acc_next  = '0;
        end
        else if ((cmd.sum_step || cmd.walk_step) && issue)
        begin
            addr_next    = addr_reg + 1'b1;
            rd_pend_next = 1'b1;
        end

        if ((cmd.sum_step || cmd.walk_step) && rd_pend_reg)
        begin
            acc_next = acc_sum;
        end

        if (cmd.div_init)
        begin
            rem_next     = '0;
            dvd_next     = rnd_reg;
            div_cnt_next = DIV_CNT_W'(RAND_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, acc_reg})
            begin
                rem_next = TOT_W'(rem_sh - {1'b0, acc_reg});
            end
            else
            begin
                rem_next = TOT_W'(rem_sh);
            end
            dvd_next     = {dvd_reg[RAND_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - 1'b1;
        end
    end

    // Pending selection and result formation.
    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_choice_next = pend_choice_reg;
        res_status_next  = res_status_reg;
        res_chosen_next  = res_chosen_reg;
        res_stake_next   = res_stake_reg;
        res_appr_next    = res_appr_reg;

        priority if (cmd.load_write)
        begin
            res_status_next = ST_OK;
            res_chosen_next = entry_reg;
            res_stake_next  = entry_ok ? VALUE_W'(load_val) : '0;
            res_appr_next   = 1'b0;
        end
        else if (cmd.walk_step && hit)
        begin
            pend_valid_next  = 1'b1;
            pend_choice_next = idx_d_reg;
            res_status_next  = ST_OK;
            res_chosen_next  = ENTRY_W'(idx_d_reg);
            res_stake_next   = VALUE_W'(ram_rdata);
            res_appr_next    = 1'b0;
        end
        else if (cmd.settle_write)
        begin
            pend_valid_next = 1'b0;
            res_status_next = ST_OK;
            res_chosen_next = ENTRY_W'(pend_choice_reg);
            res_stake_next  = VALUE_W'(settle_val);
            res_appr_next   = approve;
        end
        else if (cmd.res_zero)
        begin
            pend_valid_next = 1'b0;
            res_status_next = ST_ZERO_TOTAL;
            res_chosen_next = '0;
            res_stake_next  = '0;
            res_appr_next   = 1'b0;
        end
        else if (cmd.res_nopend)
        begin
            res_status_next = ST_NO_PENDING;
            res_chosen_next = '0;
            res_stake_next  = '0;
            res_appr_next   = 1'b0;
        end
        else if (cmd.res_blank)
        begin
            res_status_next = ST_OK;
            res_chosen_next = '0;
            res_stake_next  = '0;
            res_appr_next   = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= ACTIVE_RESET;
            reward_reg      <= REWARD_RESET;
            penalty_reg     <= PENALTY_RESET;
            addr_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            div_cnt_reg     <= '0;
            pend_valid_reg  <= 1'b0;
            pend_choice_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACTIVE_COUNT: active_reg  <= ACTIVE_W'(cfg_data);
                    CFG_REWARD:       reward_reg  <= cfg_data;
                    CFG_PENALTY:      penalty_reg <= cfg_data;
                    default:          active_reg  <= active_reg;
                endcase
            end
            addr_reg        <= addr_next;
            rd_pend_reg     <= rd_pend_next;
            div_cnt_reg     <= div_cnt_next;
            pend_valid_reg  <= pend_valid_next;
            pend_choice_reg <= pend_choice_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            entry_reg    <= entry;
            stake_in_reg <= stake_value;
            rnd_reg      <= random_value;
            verified_reg <= verified_count;
        end
        idx_d_reg      <= idx_d_next;
        acc_reg        <= acc_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        res_status_reg <= res_status_next;
        res_chosen_reg <= res_chosen_next;
        res_stake_reg  <= res_stake_next;
        res_appr_reg   <= res_appr_next;
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_chosen_reg <= res_chosen_reg;
            out_stake_reg  <= res_stake_reg;
            out_appr_reg   <= res_appr_reg;
        end
    end

    // Status to the controller.
    always_comb
    begin
        stat            = '0;
        stat.clear_last = (addr_reg == CNT_W'(MAX_PARTICIPANTS - 1));
        stat.scan_done  = !issue && !rd_pend_reg;
        stat.total_zero = (acc_reg == '0);
        stat.div_last   = (div_cnt_reg == '0);
        stat.hit        = hit;
        stat.pend_valid = pend_valid_reg;
    end

    assign status    = out_status_reg;
    assign chosen    = out_chosen_reg;
    assign stake_now = out_stake_reg;
    assign approved  = out_appr_reg;

    // The partial remainder stays below the total stake.
    `SWSEL_ASSERT_SAME(a_rem_below_total, cmd.div_step, rem_reg < acc_reg, "remainder too large")
    // A settle update only happens with a selection pending.
    `SWSEL_ASSERT_SAME(a_settle_pending, cmd.settle_write, pend_valid_reg, "settle without pick")
    // The walk always finds its participant before the scan runs out.
    `SWSEL_ASSERT_SAME(a_walk_finds, cmd.walk_step, !stat.scan_done, "walk ran past the table")

endmodule

// ----- design/stake_weighted_selector_unit.sv -----
// Stake weighted selector: usage summary below.
// Top level of the stake weighted selector. Depends on swsel_pkg, swsel_ctrl,
// swsel_dp and swsel_ram.
//
// Input channel (in_valid/in_ready) carries one operation per transaction: load a
// stake, select a participant, or settle the pending selection. Output channel
// (out_valid/out_ready) returns exactly one result per input transaction, in order.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and must
// only be issued while the block is idle.
// The select time is set by two passes over the single-read stake memory and a
// modulo that resolves one quotient bit per cycle over the 31-bit random value.
// One operation is in flight at a time; the next input is taken while a finished
// result still sits in the output register, which holds it until out_ready.
// After reset the stake memory is cleared by a pass over all MAX_PARTICIPANTS
// entries, during which in_ready stays low; configuration writes are taken throughout.
module stake_weighted_selector_unit #(
    parameter int MAX_PARTICIPANTS = swsel_pkg::DEF_MAX_PARTICIPANTS,
    parameter int STAKE_BITS       = swsel_pkg::DEF_STAKE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swsel_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swsel_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swsel_pkg::OP_W-1:0]         op,
    input  logic [swsel_pkg::ENTRY_W-1:0]      entry,
    input  logic [swsel_pkg::VALUE_W-1:0]      stake_value,
    input  logic [swsel_pkg::RAND_W-1:0]       random_value,
    input  logic [swsel_pkg::VCOUNT_W-1:0]     verified_count,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [swsel_pkg::STATUS_W-1:0]     status,
    output logic [swsel_pkg::ENTRY_W-1:0]      chosen,
    output logic [swsel_pkg::VALUE_W-1:0]      stake_now,
    output logic                               approved
);
    import swsel_pkg::*;

    swsel_cmd_t  cmd;
    swsel_stat_t stat;

    // Sequencer.
    swsel_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Stake memory and arithmetic.
    swsel_dp #(
        .MAX_PARTICIPANTS (MAX_PARTICIPANTS),
        .STAKE_BITS       (STAKE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .entry          (entry),
        .stake_value    (stake_value),
        .random_value   (random_value),
        .verified_count (verified_count),
        .status         (status),
        .chosen         (chosen),
        .stake_now      (stake_now),
        .approved       (approved),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
